// ----- rtl/aes_pkg.sv -----
`default_nettype none
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } cfg_reg_e;

  typedef logic [127:0] block_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // byte i of the block sits in bits 127-8i downto 120-8i
  function automatic logic [7:0] get_byte(block_t b, int unsigned i);
    return b[127 - 8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic block_t sub_shift(block_t s);
    block_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(r + 4*c) -: 8] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
      end
    end
    return t;
  endfunction

  function automatic block_t mix_columns(block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c + 1);
      a2 = get_byte(s, 4*c + 2);
      a3 = get_byte(s, 4*c + 3);
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 8*(4*c)     -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[127 - 8*(4*c + 1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[127 - 8*(4*c + 2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[127 - 8*(4*c + 3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  function automatic block_t next_round_key(block_t k, logic [7:0] rc);
    block_t n;
    logic [31:0] w;
    w = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
    n[127:96] = k[127:96] ^ w;
    n[95:64]  = k[95:64] ^ n[127:96];
    n[63:32]  = k[63:32] ^ n[95:64];
    n[31:0]   = k[31:0] ^ n[63:32];
    return n;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/aes_if.sv -----
`default_nettype none
interface aes_if #(
  parameter int unsigned Width = 128
) ();
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface aes_cfg_if ();
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [63:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

// ----- rtl/aes128_block_encrypt.sv -----
`default_nettype none
// AES-128 encryption pipeline: one 128-bit block per cycle while not stalled; a block
// passes an initial key add stage, then one register stage per round, to the result
// register. Each round key is expanded in the stage that uses it and travels with its
// word, so a block may follow a key write directly; a stall freezes all stages in place.
module aes128_block_encrypt (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  aes_cfg_if.sink   cfg,
  aes_if.sink       in,
  aes_if.source     out
);
  import aes_pkg::*;

  logic [63:0]  key_high_q, key_low_q;
  logic [127:0] rk [11];
  logic         en;
  logic         valid_q [NumRounds+1];
  logic [127:0] state_q [NumRounds+1];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg.valid) begin
      unique case (cfg_reg_e'(cfg.index))
        REG_KEY_HIGH: key_high_q <= cfg.wdata;
        REG_KEY_LOW:  key_low_q  <= cfg.wdata;
        default: ;
      endcase
    end
  end

  aes_key_sched u_key (
    .clk_i (clk_i),
    .en_i  (en),
    .key_i ({key_high_q, key_low_q}),
    .rk_o  (rk)
  );

  assign en = !valid_q[NumRounds] || out.ready;
  assign in.ready = en;

  // initial key add stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en) begin
      valid_q[0] <= in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      state_q[0] <= in.data ^ rk[0];
    end
  end

  for (genvar r = 1; r <= NumRounds; r++) begin : g_round
    aes_round #(.LastRound(r == NumRounds)) u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_q[r-1]),
      .state_i (state_q[r-1]),
      .rk_i    (rk[r]),
      .valid_o (valid_q[r]),
      .state_o (state_q[r])
    );
  end

  assign out.valid = valid_q[NumRounds];
  assign out.data  = state_q[NumRounds];

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out.valid && !out.ready |=> out.valid && $stable(out.data))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out.valid |-> in.ready)
    else $error("pipeline stalled with empty output");
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in.valid && in.ready |=> valid_q[0])
    else $error("item lost in pipeline");
endmodule
`default_nettype wire

// ----- rtl/aes_key_sched.sv -----
`default_nettype none
module aes_key_sched (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire logic [127:0] key_i,
  output logic [127:0]      rk_o [11]
);
  import aes_pkg::*;

  // each stage carries the round key of the word it holds
  logic [127:0] rk_q [NumRounds];

  always_comb begin
    rk_o[0] = key_i;
    for (int r = 1; r <= NumRounds; r++) begin
      rk_o[r] = next_round_key(rk_q[r-1], RCON[r-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rk_q[0] <= key_i;
      for (int r = 1; r < NumRounds; r++) begin
        rk_q[r] <= rk_o[r];
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/aes_round.sv -----
`default_nettype none
module aes_round #(
  parameter bit LastRound = 1'b0
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire logic         valid_i,
  input  wire logic [127:0] state_i,
  input  wire logic [127:0] rk_i,
  output logic              valid_o,
  output logic [127:0]      state_o
);
  import aes_pkg::*;

  logic [127:0] state_d, state_q;
  logic         valid_q;

  always_comb begin
    if (LastRound) begin
      state_d = sub_shift(state_i) ^ rk_i;
    end else begin
      state_d = mix_columns(sub_shift(state_i)) ^ rk_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
endmodule
`default_nettype wire
